// ===== rtl/nbm_pkg.sv =====
`default_nettype none

package nbm_pkg;

  localparam int PRG_BANK_BITS = 6;
  localparam int CHR_SLOTS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
  localparam int PRG_REGS = 4;
  localparam int PRG_IDX_W = $clog2(PRG_REGS);
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] PRG_FIELD_MASK = 8'((1 << PRG_BANK_BITS) - 1);
  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 7'd64;
  localparam logic [1:0] RAM_ENABLE_BITS = 2'b11;

  localparam logic [7:0] PRG_RESET [PRG_REGS] = '{8'h40, 8'h00, 8'h01, 8'h02};

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE  = 2'd0,
    FUNC_TICK       = 2'd1,
    FUNC_PPU_LOOKUP = 2'd2,
    FUNC_CPU_LOOKUP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TGT_ROM      = 2'd0,
    TGT_RAM      = 2'd1,
    TGT_UNMAPPED = 2'd2
  } target_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRG_BANK_COUNT = 1'b0,
    REG_HAS_RAM        = 1'b1
  } cfg_reg_t;

  localparam logic [3:0] CMD_CHR_FIRST = 4'h0;
  localparam logic [3:0] CMD_CHR_LAST  = 4'h7;
  localparam logic [3:0] CMD_PRG_FIRST = 4'h8;
  localparam logic [3:0] CMD_PRG_LAST  = 4'hB;
  localparam logic [3:0] CMD_MIRROR    = 4'hC;
  localparam logic [3:0] CMD_IRQ_CTRL  = 4'hD;
  localparam logic [3:0] CMD_COUNT_LO  = 4'hE;
  localparam logic [3:0] CMD_COUNT_HI  = 4'hF;

  localparam logic [2:0] WIN_CHR_LO  = 3'b000;
  localparam logic [2:0] WIN_PRG_RAM = 3'b011;
  localparam logic [2:0] WIN_CMD     = 3'b100;
  localparam logic [2:0] WIN_PARAM   = 3'b101;
  localparam logic [2:0] WIN_FIXED   = 3'b111;

  localparam logic [1:0] IRQ_CTRL_ALL = 2'b11;

  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0] bank;
    target_t    target;
    logic       ram_write;
    logic       irq;
    logic [1:0] mirror;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/nbm_if.sv =====
`default_nettype none

interface nbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, func, address, data, input ready);
  modport sink (input valid, func, address, data, output ready);
endinterface

interface nbm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] bank;
  logic [1:0] target;
  logic       ram_write;
  logic       irq;
  logic [1:0] mirror;

  modport source (output valid, bank, target, ram_write, irq, mirror, input ready);
  modport sink (input valid, bank, target, ram_write, irq, mirror, output ready);
endinterface

interface nbm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/nbm_core.sv =====
`default_nettype none

module nbm_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            acc,
  input  wire nbm_pkg::req_t                   req_d,
  input  wire logic                            cfg_we,
  input  wire logic [nbm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [nbm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output nbm_pkg::rsp_t                        rsp_d
);
  import nbm_pkg::*;

  logic [COUNT_W-1:0] prg_bank_count;
  logic               has_ram;
  logic [3:0]         command_latch;
  logic [7:0]         chr_bank [CHR_SLOTS];
  logic [7:0]         prg_bank [PRG_REGS];
  logic [1:0]         mirror_select;
  logic [1:0]         irq_control;
  logic [15:0]        irq_counter;
  logic               irq_pending;

  logic [3:0]         command_latch_next;
  logic [7:0]         chr_bank_next [CHR_SLOTS];
  logic [7:0]         prg_bank_next [PRG_REGS];
  logic [1:0]         mirror_select_next;
  logic [1:0]         irq_control_next;
  logic [15:0]        irq_counter_next;
  logic               irq_pending_next;

  logic [7:0]         mask;
  logic [PRG_IDX_W-1:0] prg_idx;

  assign mask = ({1'b0, prg_bank_count} - 8'd1) & PRG_FIELD_MASK;
  assign prg_idx = PRG_IDX_W'(2'd1 + req_d.address[14:13]);

  always_comb begin
    command_latch_next = command_latch;
    chr_bank_next      = chr_bank;
    prg_bank_next      = prg_bank;
    mirror_select_next = mirror_select;
    irq_control_next   = irq_control;
    irq_counter_next   = irq_counter;
    irq_pending_next   = irq_pending;
    rsp_d.bank         = 8'd0;
    rsp_d.target       = TGT_UNMAPPED;
    rsp_d.ram_write    = 1'b0;

    unique case (req_d.func)
      FUNC_CPU_WRITE: begin
        if (req_d.address[15:13] == WIN_PRG_RAM) begin
          rsp_d.ram_write = (prg_bank[0][7:6] == RAM_ENABLE_BITS) && has_ram;
        end else if (req_d.address[15:13] == WIN_CMD) begin
          command_latch_next = req_d.data[3:0];
        end else if (req_d.address[15:13] == WIN_PARAM) begin
          unique case (command_latch) inside
            [CMD_CHR_FIRST:CMD_CHR_LAST]: begin
              chr_bank_next[command_latch[CHR_IDX_W-1:0]] = req_d.data;
            end
            [CMD_PRG_FIRST:CMD_PRG_LAST]: begin
              prg_bank_next[command_latch[PRG_IDX_W-1:0]] = req_d.data;
            end
            CMD_MIRROR: begin
              mirror_select_next = req_d.data[1:0];
            end
            CMD_IRQ_CTRL: begin
              irq_control_next = {req_d.data[7], req_d.data[0]};
              irq_pending_next = 1'b0;
            end
            CMD_COUNT_LO: begin
              irq_counter_next = {irq_counter[15:8], req_d.data};
            end
            default: begin
              irq_counter_next = {req_d.data, irq_counter[7:0]};
            end
          endcase
        end
      end
      FUNC_TICK: begin
        if (irq_control[1]) begin
          irq_counter_next = irq_counter - 16'd1;
          if (irq_counter == 16'd1 && irq_control == IRQ_CTRL_ALL) begin
            irq_pending_next = 1'b1;
          end
        end
      end
      FUNC_PPU_LOOKUP: begin
        if (req_d.address[15:13] == WIN_CHR_LO) begin
          rsp_d.bank   = chr_bank[req_d.address[10 +: CHR_IDX_W]];
          rsp_d.target = TGT_ROM;
        end
      end
      default: begin
        if (req_d.address[15:13] == WIN_FIXED) begin
          rsp_d.bank   = mask;
          rsp_d.target = TGT_ROM;
        end else if (req_d.address[15]) begin
          rsp_d.bank   = prg_bank[prg_idx] & mask;
          rsp_d.target = TGT_ROM;
        end else if (req_d.address[15:13] == WIN_PRG_RAM) begin
          if (!prg_bank[0][6]) begin
            rsp_d.bank   = prg_bank[0] & mask;
            rsp_d.target = TGT_ROM;
          end else if (prg_bank[0][7] && has_ram) begin
            rsp_d.target = TGT_RAM;
          end
        end
      end
    endcase

    rsp_d.irq    = irq_pending_next;
    rsp_d.mirror = mirror_select_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      has_ram        <= 1'b0;
      command_latch  <= 4'd0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_bank[i] <= 8'(i);
      end
      prg_bank       <= PRG_RESET;
      mirror_select  <= 2'd0;
      irq_control    <= 2'd0;
      irq_counter    <= 16'd0;
      irq_pending    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_PRG_BANK_COUNT: prg_bank_count <= cfg_wdata[COUNT_W-1:0];
          default:            has_ram <= cfg_wdata[0];
        endcase
      end
      if (acc) begin
        command_latch <= command_latch_next;
        chr_bank      <= chr_bank_next;
        prg_bank      <= prg_bank_next;
        mirror_select <= mirror_select_next;
        irq_control   <= irq_control_next;
        irq_counter   <= irq_counter_next;
        irq_pending   <= irq_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nbm_skid.sv =====
`default_nettype none

module nbm_skid (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire nbm_pkg::rsp_t  push_data,
  output logic                push_ready,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output nbm_pkg::rsp_t       pop_data
);
  import nbm_pkg::*;

  logic main_valid;
  rsp_t main_item;
  logic skid_valid;
  rsp_t skid_item;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && pop_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid && pop_ready) begin
      main_item <= skid_valid ? skid_item : push_data;
    end else if (push && !main_valid) begin
      main_item <= push_data;
    end
    if (push && main_valid && !pop_ready) begin
      skid_item <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nes_fme7_bank_mapper_top.sv =====
// Each result is registered in the output buffer when its item is accepted on req.
// Throughput: one item per cycle; a two-entry output buffer keeps req ready
// while one result waits, so req stalls only when two results are unclaimed.
// Configuration writes are taken in every cycle and act from the next cycle.
// Reset (rst, synchronous, active high) restores the power-up bank registers,
// clears the command, mirroring and interrupt state, and empties the output.
`default_nettype none

module nes_fme7_bank_mapper_top (
  input  wire logic clk,
  input  wire logic rst,
  nbm_req_if.sink   req,
  nbm_rsp_if.source rsp,
  nbm_cfg_if.sink   cfg
);
  import nbm_pkg::*;

  logic acc;
  req_t req_d;
  rsp_t rsp_d;
  rsp_t rsp_q;

  assign acc   = req.valid && req.ready;
  assign req_d = '{func: func_t'(req.func), address: req.address, data: req.data};

  assign cfg.ready = 1'b1;

  nbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .req_d     (req_d),
    .cfg_we    (cfg.valid),
    .cfg_idx   (cfg.index),
    .cfg_wdata (cfg.wdata),
    .rsp_d     (rsp_d)
  );

  nbm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (acc),
    .push_data  (rsp_d),
    .push_ready (req.ready),
    .pop_valid  (rsp.valid),
    .pop_ready  (rsp.ready),
    .pop_data   (rsp_q)
  );

  assign rsp.bank      = rsp_q.bank;
  assign rsp.target    = rsp_q.target;
  assign rsp.ram_write = rsp_q.ram_write;
  assign rsp.irq       = rsp_q.irq;
  assign rsp.mirror    = rsp_q.mirror;

endmodule

`default_nettype wire

// ===== rtl/nbm_checker.sv =====
`default_nettype none

module nbm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_bank,
  input wire logic [1:0] rsp_target,
  input wire logic       rsp_ram_write,
  input wire logic       rsp_irq,
  input wire logic [1:0] rsp_mirror
);
  import nbm_pkg::*;

  logic [1:0] outstanding;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else if (req_acc && !rsp_acc) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_acc && !req_acc) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Result item dropped while stalled.");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable({rsp_bank, rsp_target, rsp_ram_write,
                                         rsp_irq, rsp_mirror}))
    else $error("Stalled result item changed.");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 2'd0)
    else $error("Result item shown with no item outstanding.");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding == 2'd2 |-> !req_ready)
    else $error("Item accepted with the output buffer full.");

  a_ram_write_unmapped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ram_write |-> rsp_target == TGT_UNMAPPED && rsp_bank == 8'd0)
    else $error("Work RAM write item carries a lookup result.");

endmodule

bind nes_fme7_bank_mapper_top nbm_checker u_nbm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_bank      (rsp.bank),
  .rsp_target    (rsp.target),
  .rsp_ram_write (rsp.ram_write),
  .rsp_irq       (rsp.irq),
  .rsp_mirror    (rsp.mirror)
);

`default_nettype wire
